/* rtl/clat_pkg.sv */
// ----------------------------------------------------------------------------
// clat_pkg
// Shared widths, character codes and the control and status bundles between
// the tokenizer controller and its datapath.
// ----------------------------------------------------------------------------
package clat_pkg;

    localparam int UNIT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;

    localparam int MAX_ARGS_DEF  = 63;
    localparam int SLASH_MAX_DEF = 32;

    localparam logic [UNIT_W-1:0] CH_BLANK     = 16'h0020;
    localparam logic [UNIT_W-1:0] CH_TAB       = 16'h0009;
    localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_ASCII_END = 16'h0080;

    localparam logic [BYTE_W-1:0] BYTE_QUESTION  = 8'h3F;
    localparam logic [BYTE_W-1:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] BYTE_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] BYTE_ZERO      = 8'h00;

    typedef struct packed {
        logic load;
        logic dec_slash;
        logic sel_slash;
        logic sel_byte1;
    } t_dp_cmd;

    typedef struct packed {
        logic new_slash_nz;
        logic new_byte1;
        logic new_zero2;
        logic slash_one;
        logic byte1_vld;
        logic zero2_vld;
    } t_dp_status;

endpackage

/* rtl/command_line_argument_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// command_line_argument_tokenizer_core
// Splits a UTF-16 command line into zero-terminated ASCII arguments.
// ----------------------------------------------------------------------------
// Each accepted code unit produces between zero and SLASH_MAX plus two result
// transfers, one per cycle while i_stall is low: first any pending backslashes,
// then the literal byte or terminator, then a final terminator when the unit
// ends the line. The next unit is taken in the same cycle as the final result
// of the previous one, so the input stalls while a result other than the last
// of a unit is delivered, and while the output is stalled.
module command_line_argument_tokenizer_core #(
    parameter int MAX_ARGS  = clat_pkg::MAX_ARGS_DEF,
    parameter int SLASH_MAX = clat_pkg::SLASH_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [clat_pkg::UNIT_W-1:0]   i_code_unit,
    input  logic                          i_last_unit,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [clat_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [clat_pkg::COUNT_W-1:0]  o_arg_number,
    output logic                          o_slash_overflow,
    output logic                          o_last_of_run
);

    clat_pkg::t_dp_cmd    cmd;
    clat_pkg::t_dp_status status;

    clat_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_last_of_run (o_last_of_run),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    clat_dp #(
        .MAX_ARGS  (MAX_ARGS),
        .SLASH_MAX (SLASH_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_code_unit      (i_code_unit),
        .i_last_unit      (i_last_unit),
        .o_out_byte       (o_out_byte),
        .o_arg_number     (o_arg_number),
        .o_slash_overflow (o_slash_overflow)
    );

endmodule

/* rtl/clat_dp.sv */
// ----------------------------------------------------------------------------
// clat_dp
// Tokenizer datapath: parser state, decoding of one code unit into a result
// plan (backslash count, optional byte, optional terminator), and the result
// fields.
// ----------------------------------------------------------------------------
module clat_dp #(
    parameter int MAX_ARGS  = clat_pkg::MAX_ARGS_DEF,
    parameter int SLASH_MAX = clat_pkg::SLASH_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  clat_pkg::t_dp_cmd                i_cmd,
    output clat_pkg::t_dp_status             o_status,
    input  logic [clat_pkg::UNIT_W-1:0]      i_code_unit,
    input  logic                             i_last_unit,
    output logic [clat_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [clat_pkg::COUNT_W-1:0]     o_arg_number,
    output logic                             o_slash_overflow
);

    localparam int CW = clat_pkg::COUNT_W;

    logic          r_inside, n_inside;
    logic          r_quote, n_quote;
    logic [CW-1:0] r_pending, n_pending;
    logic [CW-1:0] r_count, n_count;
    logic          r_stopped, n_stopped;
    logic          r_run_ovf, n_run_ovf;

    logic [CW-1:0]                 r_slash, n_slash;
    logic                          r_byte1_vld, n_byte1_vld;
    logic [clat_pkg::BYTE_W-1:0]   r_byte1, n_byte1;
    logic                          r_zero2, n_zero2;
    logic                          r_ovf, n_ovf;
    logic [CW-1:0]                 r_argn;

    logic        blank, is_bs, is_qt;
    logic [CW:0] count_inc;

    always_comb begin
        blank     = (i_code_unit == clat_pkg::CH_BLANK) || (i_code_unit == clat_pkg::CH_TAB);
        is_bs     = (i_code_unit == clat_pkg::CH_BACKSLASH);
        is_qt     = (i_code_unit == clat_pkg::CH_QUOTE);
        count_inc = {1'b0, r_count} + {{CW{1'b0}}, 1'b1};

        n_inside    = r_inside;
        n_quote     = r_quote;
        n_pending   = r_pending;
        n_count     = r_count;
        n_stopped   = r_stopped;
        n_run_ovf   = r_run_ovf;
        n_slash     = '0;
        n_byte1_vld = 1'b0;
        n_byte1     = clat_pkg::BYTE_ZERO;
        n_zero2     = 1'b0;
        n_ovf       = r_run_ovf;

        if (!r_stopped) begin
            if (!r_inside && !blank) begin
                n_inside  = 1'b1;
                n_quote   = 1'b0;
                n_pending = '0;
                n_run_ovf = 1'b0;
                n_ovf     = 1'b0;
            end
            if (n_inside) begin
                if (is_bs) begin
                    if (n_pending < CW'(SLASH_MAX)) begin
                        n_pending = n_pending + CW'(1);
                    end else begin
                        n_run_ovf = 1'b1;
                        n_ovf     = 1'b1;
                    end
                end else if (is_qt) begin
                    n_slash = n_pending >> 1;
                    if (n_pending[0]) begin
                        n_byte1_vld = 1'b1;
                        n_byte1     = clat_pkg::BYTE_QUOTE;
                    end else begin
                        n_quote = !n_quote;
                    end
                    n_pending = '0;
                    n_run_ovf = 1'b0;
                end else begin
                    n_slash     = n_pending;
                    n_pending   = '0;
                    n_run_ovf   = 1'b0;
                    n_byte1_vld = 1'b1;
                    if (!n_quote && blank) begin
                        n_byte1   = clat_pkg::BYTE_ZERO;
                        n_inside  = 1'b0;
                        n_quote   = 1'b0;
                        n_count   = count_inc[CW-1:0];
                        n_stopped = (count_inc >= (CW+1)'(MAX_ARGS));
                    end else if (i_code_unit < clat_pkg::CH_ASCII_END) begin
                        n_byte1 = i_code_unit[clat_pkg::BYTE_W-1:0];
                    end else begin
                        n_byte1 = clat_pkg::BYTE_QUESTION;
                    end
                end
                if (i_last_unit && n_inside) begin
                    if (is_bs) begin
                        n_slash = n_pending;
                    end
                    n_zero2 = 1'b1;
                end
            end
        end

        if (i_last_unit) begin
            n_inside  = 1'b0;
            n_quote   = 1'b0;
            n_pending = '0;
            n_count   = '0;
            n_stopped = 1'b0;
            n_run_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_quote   <= 1'b0;
            r_pending <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_run_ovf <= 1'b0;
            r_slash   <= '0;
        end else if (i_cmd.load) begin
            r_inside  <= n_inside;
            r_quote   <= n_quote;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_stopped <= n_stopped;
            r_run_ovf <= n_run_ovf;
            r_slash   <= n_slash;
        end else if (i_cmd.dec_slash) begin
            r_slash <= r_slash - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte1_vld <= n_byte1_vld;
            r_byte1     <= n_byte1;
            r_zero2     <= n_zero2;
            r_ovf       <= n_ovf;
            r_argn      <= r_count;
        end
    end

    assign o_status.new_slash_nz = (n_slash != '0);
    assign o_status.new_byte1    = n_byte1_vld;
    assign o_status.new_zero2    = n_zero2;
    assign o_status.slash_one    = (r_slash == CW'(1));
    assign o_status.byte1_vld    = r_byte1_vld;
    assign o_status.zero2_vld    = r_zero2;

    assign o_out_byte       = i_cmd.sel_slash ? clat_pkg::BYTE_BACKSLASH :
                              i_cmd.sel_byte1 ? r_byte1 : clat_pkg::BYTE_ZERO;
    assign o_arg_number     = r_argn;
    assign o_slash_overflow = r_ovf;

endmodule

/* rtl/clat_ctrl.sv */
// ----------------------------------------------------------------------------
// clat_ctrl
// Tokenizer controller: steps through the backslash run, the optional byte
// and the optional terminator of each code unit, and runs both handshakes.
// ----------------------------------------------------------------------------
module clat_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_last_of_run,
    output clat_pkg::t_dp_cmd     o_cmd,
    input  clat_pkg::t_dp_status  i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLASH,
        ST_BYTE1,
        ST_BYTE2
    } t_state;

    t_state r_state, n_state, first_state;
    logic   in_xfer, out_xfer, last_res;

    always_comb begin
        unique case (r_state)
            ST_SLASH: last_res = i_status.slash_one && !i_status.byte1_vld
                                 && !i_status.zero2_vld;
            ST_BYTE1: last_res = !i_status.zero2_vld;
            ST_BYTE2: last_res = 1'b1;
            default:  last_res = 1'b0;
        endcase

        o_valid  = (r_state != ST_IDLE);
        o_stall  = !((r_state == ST_IDLE) || (last_res && !i_stall));
        in_xfer  = i_valid && !o_stall;
        out_xfer = o_valid && !i_stall;

        if (i_status.new_slash_nz) begin
            first_state = ST_SLASH;
        end else if (i_status.new_byte1) begin
            first_state = ST_BYTE1;
        end else if (i_status.new_zero2) begin
            first_state = ST_BYTE2;
        end else begin
            first_state = ST_IDLE;
        end

        n_state = r_state;
        if (r_state == ST_IDLE) begin
            if (in_xfer) begin
                n_state = first_state;
            end
        end else if (out_xfer) begin
            if (last_res) begin
                n_state = in_xfer ? first_state : ST_IDLE;
            end else begin
                unique case (r_state)
                    ST_SLASH: begin
                        if (i_status.slash_one) begin
                            n_state = i_status.byte1_vld ? ST_BYTE1 : ST_BYTE2;
                        end
                    end
                    ST_BYTE1: n_state = ST_BYTE2;
                    default:  n_state = r_state;
                endcase
            end
        end

        o_cmd.load      = in_xfer;
        o_cmd.dec_slash = out_xfer && (r_state == ST_SLASH);
        o_cmd.sel_slash = (r_state == ST_SLASH);
        o_cmd.sel_byte1 = (r_state == ST_BYTE1);
        o_last_of_run   = last_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
